>>> design/tabpc_pkg.sv
// Package for the time/address block placement checker.
// Holds the word structs, command and status codes, and the controller states.
// Has no dependencies of its own.
package tabpc_pkg;

  typedef enum logic [1:0] {
    CMD_PLACE  = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RANGE    = 3'd1,
    ST_IN_STEP  = 3'd2,
    ST_EARLIER  = 3'd3,
    ST_FULL     = 3'd4,
    ST_REJECTED = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] block_address;
    logic [15:0] block_size;
    logic [7:0]  lifetime;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] lowest_address;
    logic [15:0] highest_end;
    logic [7:0]  steps_committed;
  } out_word_t;

  // One block as held in the kept and pending memories.
  typedef struct packed {
    logic [15:0] start;
    logic [15:0] size;
    logic [7:0]  step;
    logic [7:0]  life;
  } blk_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_PSCAN  = 7'b0000010,
    S_KSCAN  = 7'b0000100,
    S_CCOUNT = 7'b0001000,
    S_CCOPY  = 7'b0010000,
    S_CDONE  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  // Positive-length intersection of [a1,a2) and [b1,b2).
  function automatic logic spans_meet(input logic [16:0] a1, input logic [16:0] a2,
                                      input logic [16:0] b1, input logic [16:0] b2);
    logic [16:0] lo;
    logic [16:0] hi;
    lo = (a1 > b1) ? a1 : b1;
    hi = (a2 < b2) ? a2 : b2;
    return hi > lo;
  endfunction

endpackage

>>> design/tabpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the kept and pending block tables; no dependencies.
module tabpc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/time_address_block_placement_checker.sv
// Top level of the time/address block placement checker; uses tabpc_pkg, tabpc_ram.
// Result word: a place scans the pending and then the kept table; a commit counts the
// pending table, then copies it (no copy when the kept table or step count is full);
// clear, unused commands, rejected commits and out-of-range places go straight to the
// result. One word at a time: in_ready is high only in idle, after the result is out.
// Reset (async, active low) empties the tables, zeroes range and steps, memory_size 1024.
module time_address_block_placement_checker
  import tabpc_pkg::*;
#(
  parameter int KEPT_ENTRIES = 64,
  parameter int STEP_ENTRIES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o,
  input  logic      cfg_we_i,
  input  logic [15:0] cfg_data_i
);

  localparam int KAW = (KEPT_ENTRIES > 1) ? $clog2(KEPT_ENTRIES) : 1;
  localparam int PAW = (STEP_ENTRIES > 1) ? $clog2(STEP_ENTRIES) : 1;
  localparam int KCW = $clog2(KEPT_ENTRIES + 1);
  localparam int PCW = $clog2(STEP_ENTRIES + 1);
  localparam int NSW = KCW + PCW;
  localparam int BW  = $bits(blk_t);

  state_e        state_q, state_d;
  in_word_t      cmd_q, cmd_d;
  logic [15:0]   mem_size_q, mem_size_d;
  logic [KCW-1:0] kept_cnt_q, kept_cnt_d;
  logic [PCW-1:0] pend_cnt_q, pend_cnt_d;
  logic          failed_q, failed_d;
  logic [7:0]    step_q, step_d;
  logic [15:0]   lo_q, lo_d, hi_q, hi_d;
  logic [PCW:0]  idx_q, idx_d;     // scan index, one wider to hold the end
  logic          rvld_q, rvld_d;   // read data valid this cycle
  logic [PCW-1:0] need_q, need_d;
  logic [15:0]   slo_q, slo_d;
  logic [16:0]   shi_q, shi_d;
  logic [2:0]    stat_q, stat_d;
  logic [KAW:0]  kidx_q, kidx_d;
  logic          out_valid_q, out_valid_d;

  logic          k_we, p_we;
  logic [KAW-1:0] k_waddr, k_raddr;
  logic [PAW-1:0] p_waddr, p_raddr;
  blk_t          k_wdata, p_wdata, k_rdata, p_rdata;

  tabpc_ram #(.Width(BW), .Depth(KEPT_ENTRIES), .AddrW(KAW)) u_kept (
    .clk_i(clk_i), .we_i(k_we), .waddr_i(k_waddr), .wdata_i(k_wdata),
    .raddr_i(k_raddr), .rdata_o(k_rdata)
  );

  tabpc_ram #(.Width(BW), .Depth(STEP_ENTRIES), .AddrW(PAW)) u_pend (
    .clk_i(clk_i), .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  logic [16:0] new_end;
  logic        zero_area;
  assign new_end   = {1'b0, cmd_q.block_address} + {1'b0, cmd_q.block_size};
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencer: scans the tables one entry per cycle through their registered read ports.
  always_comb begin
    state_d = state_q; cmd_d = cmd_q; mem_size_d = mem_size_q;
    kept_cnt_d = kept_cnt_q; pend_cnt_d = pend_cnt_q; failed_d = failed_q;
    step_d = step_q; lo_d = lo_q; hi_d = hi_q; idx_d = idx_q; rvld_d = 1'b0;
    need_d = need_q; slo_d = slo_q; shi_d = shi_q; stat_d = stat_q;
    kidx_d = kidx_q; out_valid_d = out_valid_q;
    k_we = 1'b0; p_we = 1'b0;
    k_waddr = kept_cnt_q[KAW-1:0]; p_waddr = pend_cnt_q[PAW-1:0];
    k_raddr = idx_q[KAW-1:0]; p_raddr = idx_q[PAW-1:0];
    k_wdata = p_rdata;
    k_wdata.step = step_q;
    p_wdata = '{start: cmd_q.block_address, size: cmd_q.block_size,
                step: step_q, life: cmd_q.lifetime};
    zero_area = (cmd_q.block_size == 16'd0) || (cmd_q.lifetime == 8'd0);
    if (cfg_we_i) mem_size_d = cfg_data_i;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = in_data_i;
          idx_d = '0;
          state_d = S_OUT;
          stat_d = ST_OK;
          case (in_data_i.command)
            CMD_PLACE: begin
              if ({1'b0, in_data_i.block_address} + {1'b0, in_data_i.block_size}
                  > {1'b0, mem_size_q}) begin
                stat_d = ST_RANGE; failed_d = 1'b1;
              end else begin
                state_d = S_PSCAN;
              end
            end
            CMD_COMMIT: begin
              if (failed_q) begin
                stat_d = ST_REJECTED; pend_cnt_d = '0; failed_d = 1'b0;
              end else begin
                need_d = '0; state_d = S_CCOUNT;
              end
            end
            CMD_CLEAR: begin
              kept_cnt_d = '0; pend_cnt_d = '0; failed_d = 1'b0;
              step_d = '0; lo_d = '0; hi_d = '0;
            end
            default: ;
          endcase
        end
      end
      // Same-step overlap: compare against each pending block.
      S_PSCAN: begin
        if (rvld_q && spans_meet({1'b0, p_rdata.start},
            {1'b0, p_rdata.start} + {1'b0, p_rdata.size},
            {1'b0, cmd_q.block_address}, new_end)) begin
          stat_d = ST_IN_STEP; failed_d = 1'b1; state_d = S_OUT;
        end else if (idx_q[PCW-1:0] == pend_cnt_q || idx_q > (PCW+1)'(STEP_ENTRIES)) begin
          idx_d = '0; kidx_d = '0; state_d = S_KSCAN;
        end else begin
          p_raddr = idx_q[PAW-1:0]; idx_d = idx_q + 1'b1; rvld_d = 1'b1;
          if (idx_q[PCW-1:0] + 1'b1 > pend_cnt_q) rvld_d = 1'b0;
        end
        if (idx_q[PCW-1:0] >= pend_cnt_q && !(rvld_q && state_d == S_OUT)) begin
          kidx_d = '0; state_d = S_KSCAN;
        end
      end
      // Earlier-step overlap: compare the rectangle against each kept block.
      S_KSCAN: begin
        k_raddr = kidx_q[KAW-1:0];
        if (rvld_q && !zero_area &&
            spans_meet({9'd0, k_rdata.step}, {9'd0, k_rdata.step} + {9'd0, k_rdata.life},
                       {9'd0, step_q}, {9'd0, step_q} + {9'd0, cmd_q.lifetime}) &&
            spans_meet({1'b0, k_rdata.start}, {1'b0, k_rdata.start} + {1'b0, k_rdata.size},
                       {1'b0, cmd_q.block_address}, new_end)) begin
          stat_d = ST_EARLIER; failed_d = 1'b1; state_d = S_OUT;
        end else if (kidx_q[KCW-1:0] >= kept_cnt_q) begin
          if (!rvld_q || kidx_q[KCW-1:0] == kept_cnt_q) begin
            state_d = S_OUT;
            if (pend_cnt_q >= PCW'(STEP_ENTRIES)) begin
              stat_d = ST_FULL; failed_d = 1'b1;
            end else begin
              p_we = 1'b1; pend_cnt_d = pend_cnt_q + 1'b1;
            end
          end
        end else begin
          kidx_d = kidx_q + 1'b1; rvld_d = 1'b1;
        end
      end
      // Commit: count blocks of nonzero area and the step's address range.
      S_CCOUNT: begin
        if (rvld_q) begin
          if (p_rdata.size != 16'd0 && p_rdata.life != 8'd0) need_d = need_q + 1'b1;
          if (idx_q == (PCW+1)'(1) || p_rdata.start < slo_q) slo_d = p_rdata.start;
          if (idx_q == (PCW+1)'(1) ||
              {1'b0, p_rdata.start} + {1'b0, p_rdata.size} > shi_q)
            shi_d = {1'b0, p_rdata.start} + {1'b0, p_rdata.size};
        end
        if (idx_q == (PCW+1)'(0)) begin
          slo_d = '0; shi_d = '0;
        end
        if (idx_q[PCW-1:0] < pend_cnt_q && idx_q <= (PCW+1)'(STEP_ENTRIES)) begin
          p_raddr = idx_q[PAW-1:0]; idx_d = idx_q + 1'b1; rvld_d = 1'b1;
        end else if (!rvld_q || idx_q[PCW-1:0] == pend_cnt_q) begin
          if (!rvld_q) state_d = S_CDONE;
        end
        if (rvld_q && idx_q[PCW-1:0] == pend_cnt_q) state_d = S_CDONE;
        if (pend_cnt_q == '0) state_d = S_CDONE;
      end
      S_CDONE: begin
        if (step_q == 8'd255 ||
            (NSW'(kept_cnt_q) + NSW'(need_q)) > NSW'(KEPT_ENTRIES)) begin
          stat_d = ST_FULL; pend_cnt_d = '0; failed_d = 1'b0; state_d = S_OUT;
        end else begin
          idx_d = '0; state_d = S_CCOPY;
        end
      end
      // Copy pending blocks of nonzero area into the kept table.
      S_CCOPY: begin
        if (rvld_q && p_rdata.size != 16'd0 && p_rdata.life != 8'd0) begin
          k_we = 1'b1; kept_cnt_d = kept_cnt_q + 1'b1;
        end
        if (idx_q[PCW-1:0] < pend_cnt_q && !(rvld_q && idx_q[PCW-1:0] == pend_cnt_q)) begin
          p_raddr = idx_q[PAW-1:0]; idx_d = idx_q + 1'b1; rvld_d = 1'b1;
        end else begin
          state_d = S_OUT;
          if (step_q == 8'd0) begin
            lo_d = slo_q; hi_d = shi_q[15:0];
          end else begin
            if (slo_q < lo_q) lo_d = slo_q;
            if (shi_q[15:0] > hi_q) hi_d = shi_q[15:0];
          end
          step_d = step_q + 8'd1; pend_cnt_d = '0; failed_d = 1'b0;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; mem_size_q <= 16'd1024; kept_cnt_q <= '0; pend_cnt_q <= '0;
      failed_q <= 1'b0; step_q <= '0; lo_q <= '0; hi_q <= '0; idx_q <= '0;
      rvld_q <= 1'b0; need_q <= '0; kidx_q <= '0; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; mem_size_q <= mem_size_d; kept_cnt_q <= kept_cnt_d;
      pend_cnt_q <= pend_cnt_d; failed_q <= failed_d; step_q <= step_d;
      lo_q <= lo_d; hi_q <= hi_d; idx_q <= idx_d; rvld_q <= rvld_d;
      need_q <= need_d; kidx_q <= kidx_d; out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; slo_q <= slo_d; shi_q <= shi_d; stat_q <= stat_d;
    if (state_q == S_OUT && (!out_valid_q || out_ready_i)) begin
      out_data_o <= '{status: stat_q, lowest_address: lo_q, highest_end: hi_q,
                      steps_committed: step_q};
    end
  end

  // Checks.
  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_cnt_q <= KCW'(KEPT_ENTRIES)) else $error("kept count overflow");
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q <= PCW'(STEP_ENTRIES)) else $error("pending count overflow");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(k_we && p_we)) else $error("both tables written at once");

endmodule
